>>> sv/gdd_pkg.sv
// Shared widths, constants, types and calendar functions for the date difference block.
`default_nettype none

package gdd_pkg;

  localparam int DAY_W   = 5;
  localparam int MON_W   = 4;
  localparam int YEAR_W  = 14;
  localparam int DIFF_W  = 23;
  localparam int ACC_W   = 25;
  localparam int OP_W    = 15;
  localparam int PROD_W  = 2 * OP_W;
  localparam int QUO_W   = 8;
  localparam int DOY_W   = 9;

  localparam logic [OP_W-1:0] DAYS_PER_YEAR = 15'd365;
  // ceil(2^21 / 100); exact quotient for dividends below 43690.
  localparam logic [OP_W-1:0] RECIP_100     = 15'd20972;
  localparam int              RECIP_SHIFT   = 21;
  localparam logic [OP_W-1:0] CENTURY       = 15'd100;
  localparam logic [OP_W-1:0] CENTURY_BIAS  = 15'd99;

  localparam logic signed [ACC_W-1:0] DIFF_MAX = 25'sd4194303;
  localparam logic signed [ACC_W-1:0] DIFF_MIN = -25'sd4194304;

  localparam logic [MON_W-1:0] MON_JAN = 4'd1;
  localparam logic [MON_W-1:0] MON_FEB = 4'd2;
  localparam logic [MON_W-1:0] MON_MAR = 4'd3;
  localparam logic [MON_W-1:0] MON_APR = 4'd4;
  localparam logic [MON_W-1:0] MON_MAY = 4'd5;
  localparam logic [MON_W-1:0] MON_JUN = 4'd6;
  localparam logic [MON_W-1:0] MON_JUL = 4'd7;
  localparam logic [MON_W-1:0] MON_AUG = 4'd8;
  localparam logic [MON_W-1:0] MON_SEP = 4'd9;
  localparam logic [MON_W-1:0] MON_OCT = 4'd10;
  localparam logic [MON_W-1:0] MON_NOV = 4'd11;
  localparam logic [MON_W-1:0] MON_DEC = 4'd12;

  typedef enum logic {
    MUL_YEAR,
    MUL_RECIP
  } mul_sel_t;

  typedef struct packed {
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     acc_clr;
    logic     acc_en;
    logic     acc_sub;
  } gdd_ctl_t;

  function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] m, input logic leap);
    logic [DAY_W-1:0] len;
    case (m)
      MON_FEB: len = leap ? 5'd29 : 5'd28;
      MON_APR, MON_JUN, MON_SEP, MON_NOV: len = 5'd30;
      MON_JAN, MON_MAR, MON_MAY, MON_JUL, MON_AUG, MON_OCT, MON_DEC: len = 5'd31;
      default: len = 5'd0;
    endcase
    return len;
  endfunction

  function automatic logic [DOY_W-1:0] month_start(input logic [MON_W-1:0] m);
    logic [DOY_W-1:0] s;
    case (m)
      MON_JAN: s = 9'd0;
      MON_FEB: s = 9'd31;
      MON_MAR: s = 9'd59;
      MON_APR: s = 9'd90;
      MON_MAY: s = 9'd120;
      MON_JUN: s = 9'd151;
      MON_JUL: s = 9'd181;
      MON_AUG: s = 9'd212;
      MON_SEP: s = 9'd243;
      MON_OCT: s = 9'd273;
      MON_NOV: s = 9'd304;
      MON_DEC: s = 9'd334;
      default: s = 9'd0;
    endcase
    return s;
  endfunction

  // An invalid month has length zero, so any day fails against it.
  function automatic logic date_ok(input logic [DAY_W-1:0] d, input logic [MON_W-1:0] m,
                                   input logic leap);
    return (d != '0) && (d <= month_len(m, leap));
  endfunction

  function automatic logic [DOY_W-1:0] day_of_year(input logic [DAY_W-1:0] d,
                                                   input logic [MON_W-1:0] m,
                                                   input logic leap);
    logic [DOY_W-1:0] n;
    n = month_start(m) + {{(DOY_W-DAY_W){1'b0}}, d} - 9'd1;
    if ((m > MON_FEB) && leap) begin
      n = n + 9'd1;
    end
    return n;
  endfunction

endpackage

`default_nettype wire

>>> sv/gdd_if.sv
// Valid/ready channel interfaces for the date pair input and the day count result.
`default_nettype none

interface gdd_in_if import gdd_pkg::*;;
  logic              valid;
  logic              ready;
  logic [DAY_W-1:0]  first_day;
  logic [MON_W-1:0]  first_month;
  logic [YEAR_W-1:0] first_year;
  logic [DAY_W-1:0]  second_day;
  logic [MON_W-1:0]  second_month;
  logic [YEAR_W-1:0] second_year;
  logic              count_end_day;

  modport source (output valid, first_day, first_month, first_year, second_day,
                  second_month, second_year, count_end_day, input ready);
  modport sink (input valid, first_day, first_month, first_year, second_day,
                second_month, second_year, count_end_day, output ready);
endinterface

interface gdd_out_if import gdd_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic signed [DIFF_W-1:0] day_difference;
  logic                     date_error;

  modport source (output valid, day_difference, date_error, input ready);
  modport sink (input valid, day_difference, date_error, output ready);
endinterface

`default_nettype wire

>>> sv/gregorian_date_difference.sv
// Top level: signed day count between two Gregorian dates, built on a shared arithmetic unit.
//
// The input channel carries two dates and a flag that counts the end day; the result
// channel carries the signed day count and an error flag. Both are valid/ready channels
// and a beat moves when valid and ready are high at a rising clock edge.
// Each date is turned into a day number (365 per year plus leap days plus day of year)
// by a sequencer that drives one constant multiplier and one accumulator. The count of
// centuries uses a multiply by a reciprocal of 100, from which the leap year test and
// the 400 year count also follow. Six steps per date, then one step for the end day
// flag and one to saturate and load the result register.
// The input is not ready while the sequencer works. The result register frees the input
// side: the next item is taken while a result still waits, and the sequencer holds in its
// last step only if the earlier result has not yet been taken when the new one is done.
// An invalid month or day in either date gives a count of zero with the error flag set.
// The count saturates to the 23-bit signed range.
// Reset (rst_n, synchronous, active low) returns the sequencer to idle and drops the
// result valid; a result not yet taken is lost.
`default_nettype none

module gregorian_date_difference import gdd_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  gdd_in_if.sink    in_chan,
  gdd_out_if.source out_chan
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_Y365,
    S_QUO,
    S_C100,
    S_C400,
    S_MD,
    S_ADJ,
    S_FIN
  } state_t;

  state_t                   state_r;
  logic                     pass_r;   // 1 while working on the first date
  logic [DAY_W-1:0]         d1_r;
  logic [MON_W-1:0]         m1_r;
  logic [YEAR_W-1:0]        y1_r;
  logic [DAY_W-1:0]         d2_r;
  logic [MON_W-1:0]         m2_r;
  logic [YEAR_W-1:0]        y2_r;
  logic                     end_r;
  logic [QUO_W-1:0]         q100_r;
  logic                     leap_r;
  logic                     err_r;
  logic signed [DIFF_W-1:0] out_diff_r;
  logic                     out_err_r;
  logic                     out_valid_r;

  gdd_ctl_t                 ctl;
  logic [OP_W-1:0]          mul_a;
  logic signed [ACC_W-1:0]  term;
  logic [PROD_W-1:0]        prod;
  logic signed [ACC_W-1:0]  acc;

  logic [DAY_W-1:0]         cur_d;
  logic [MON_W-1:0]         cur_m;
  logic [YEAR_W-1:0]        cur_y;
  logic [OP_W-1:0]          y_ext;
  logic [OP_W-1:0]          y_plus3;
  logic [QUO_W:0]           q_plus3;
  logic [OP_W-1:0]          q_times100;
  logic                     div100;
  logic                     leap_c;
  logic                     in_fire;
  logic                     out_free;
  logic signed [DIFF_W-1:0] sat_diff;

  assign in_fire  = in_chan.valid && in_chan.ready;
  assign out_free = !out_valid_r || out_chan.ready;

  always_comb begin
    cur_d   = pass_r ? d1_r : d2_r;
    cur_m   = pass_r ? m1_r : m2_r;
    cur_y   = pass_r ? y1_r : y2_r;
    y_ext   = {1'b0, cur_y};
    y_plus3 = y_ext + 15'd3;
    q_plus3 = {1'b0, q100_r} + 9'd3;
    // ceil(y/100) times 100 equals y exactly when y is a whole number of centuries.
    q_times100 = {{(OP_W-QUO_W){1'b0}}, q100_r} * CENTURY;
    div100  = (q_times100 == y_ext);
    leap_c  = (cur_y[1:0] == 2'b00) && (!div100 || (q100_r[1:0] == 2'b00));

    if (acc > DIFF_MAX) begin
      sat_diff = DIFF_MAX[DIFF_W-1:0];
    end else if (acc < DIFF_MIN) begin
      sat_diff = DIFF_MIN[DIFF_W-1:0];
    end else begin
      sat_diff = acc[DIFF_W-1:0];
    end
  end

  // The second date is added and the first subtracted, so every date term flips with the pass.
  always_comb begin
    ctl         = '0;
    ctl.mul_sel = MUL_YEAR;
    ctl.acc_sub = pass_r;
    mul_a       = y_ext;
    term        = '0;
    case (state_r)
      S_IDLE: begin
        ctl.acc_clr = in_fire;
      end
      S_MUL: begin
        ctl.mul_en = 1'b1;
      end
      S_Y365: begin
        ctl.mul_en  = 1'b1;
        ctl.mul_sel = MUL_RECIP;
        mul_a       = y_ext + CENTURY_BIAS;
        ctl.acc_en  = 1'b1;
        term        = ACC_W'(prod[DIFF_W-1:0]);
      end
      S_QUO: begin
        ctl.acc_en = 1'b1;
        term       = ACC_W'(y_plus3[OP_W-1:2]);
      end
      S_C100: begin
        ctl.acc_en  = 1'b1;
        ctl.acc_sub = !pass_r;
        term        = ACC_W'(q100_r);
      end
      S_C400: begin
        ctl.acc_en = 1'b1;
        term       = ACC_W'(q_plus3[QUO_W:2]);
      end
      S_MD: begin
        ctl.acc_en = 1'b1;
        term       = ACC_W'(day_of_year(cur_d, cur_m, leap_r));
      end
      S_ADJ: begin
        ctl.acc_en  = end_r;
        ctl.acc_sub = acc[ACC_W-1];
        term        = ACC_W'(1);
      end
      S_FIN: begin
        ctl = '0;
      end
      default: begin
        ctl = '0;
      end
    endcase
  end

  gdd_unit u_unit (
    .clk   (clk),
    .ctl   (ctl),
    .mul_a (mul_a),
    .term  (term),
    .prod  (prod),
    .acc   (acc)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pass_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // In the last step the result register is reloaded instead of cleared.
      if (out_valid_r && out_chan.ready && (state_r != S_FIN)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            d1_r    <= in_chan.first_day;
            m1_r    <= in_chan.first_month;
            y1_r    <= in_chan.first_year;
            d2_r    <= in_chan.second_day;
            m2_r    <= in_chan.second_month;
            y2_r    <= in_chan.second_year;
            end_r   <= in_chan.count_end_day;
            err_r   <= 1'b0;
            pass_r  <= 1'b0;
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          state_r <= S_Y365;
        end
        S_Y365: begin
          state_r <= S_QUO;
        end
        S_QUO: begin
          q100_r  <= prod[RECIP_SHIFT +: QUO_W];
          state_r <= S_C100;
        end
        S_C100: begin
          leap_r  <= leap_c;
          state_r <= S_C400;
        end
        S_C400: begin
          state_r <= S_MD;
        end
        S_MD: begin
          err_r <= err_r || !date_ok(cur_d, cur_m, leap_r);
          if (pass_r) begin
            state_r <= S_ADJ;
          end else begin
            pass_r  <= 1'b1;
            state_r <= S_MUL;
          end
        end
        S_ADJ: begin
          state_r <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            out_diff_r  <= err_r ? '0 : sat_diff;
            out_err_r   <= err_r;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_chan.ready           = (state_r == S_IDLE);
  assign out_chan.valid          = out_valid_r;
  assign out_chan.day_difference = out_diff_r;
  assign out_chan.date_error     = out_err_r;

endmodule

`default_nettype wire

>>> sv/gdd_unit.sv
// Shared arithmetic unit: one registered constant multiplier and one add/subtract accumulator.
`default_nettype none

module gdd_unit import gdd_pkg::*; (
  input  wire logic                    clk,
  input  wire gdd_ctl_t                ctl,
  input  wire logic [OP_W-1:0]         mul_a,
  input  wire logic signed [ACC_W-1:0] term,
  output logic [PROD_W-1:0]            prod,
  output logic signed [ACC_W-1:0]      acc
);

  logic [OP_W-1:0]         mul_b;
  logic [PROD_W-1:0]       prod_r;
  logic [PROD_W-1:0]       prod_nxt;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [ACC_W-1:0] acc_nxt;

  always_comb begin
    mul_b    = (ctl.mul_sel == MUL_YEAR) ? DAYS_PER_YEAR : RECIP_100;
    prod_nxt = mul_a * mul_b;
    if (ctl.acc_clr) begin
      acc_nxt = '0;
    end else if (ctl.acc_sub) begin
      acc_nxt = acc_r - term;
    end else begin
      acc_nxt = acc_r + term;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod_r <= prod_nxt;
    end
    if (ctl.acc_clr || ctl.acc_en) begin
      acc_r <= acc_nxt;
    end
  end

  assign prod = prod_r;
  assign acc  = acc_r;

endmodule

`default_nettype wire

>>> test/date_diff_checker.sv
// Checker for the date difference block: predicts each day count and compares result beats.
`default_nettype none

module date_diff_checker import gdd_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  gdd_in_if         in_mon,
  gdd_out_if        out_mon,
  output int        mismatches,
  output int        outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [DIFF_W-1:0] day_difference;
    logic                     date_error;
  } day_count_t;

  day_count_t expected_counts[$];

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  function automatic bit is_leap(input int unsigned y);
    return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
  endfunction

  function automatic int unsigned days_in_month(input logic [MON_W-1:0] m, input bit leap);
    case (m)
      MON_FEB:                            return leap ? 29 : 28;
      MON_APR, MON_JUN, MON_SEP, MON_NOV: return 30;
      MON_JAN, MON_MAR, MON_MAY, MON_JUL,
      MON_AUG, MON_OCT, MON_DEC:          return 31;
      default:                            return 0;
    endcase
  endfunction

  // Months outside January..December have zero length, so no day fits them.
  function automatic bit is_real_date(input logic [DAY_W-1:0] d, input logic [MON_W-1:0] m,
                                      input logic [YEAR_W-1:0] y);
    return (d != '0) && (d <= days_in_month(m, is_leap(y)));
  endfunction

  // Days elapsed since January 1 of year 0, proleptic calendar.
  function automatic longint day_index(input logic [DAY_W-1:0] d, input logic [MON_W-1:0] m,
                                       input logic [YEAR_W-1:0] y);
    int unsigned yr;
    longint      n;
    yr = y;
    n  = 365 * longint'(yr) + (yr + 3) / 4 - (yr + 99) / 100 + (yr + 399) / 400;
    for (int k = MON_JAN; k < m; k++) begin
      n += days_in_month(k[MON_W-1:0], 1'b0);
    end
    if (m > MON_FEB && is_leap(yr)) begin
      n += 1;
    end
    return n + d - 1;
  endfunction

  function automatic day_count_t predict_count(
    input logic [DAY_W-1:0] d1, input logic [MON_W-1:0] m1, input logic [YEAR_W-1:0] y1,
    input logic [DAY_W-1:0] d2, input logic [MON_W-1:0] m2, input logic [YEAR_W-1:0] y2,
    input logic end_day);
    day_count_t r;
    longint     span;
    r.day_difference = '0;
    r.date_error     = !is_real_date(d1, m1, y1) || !is_real_date(d2, m2, y2);
    if (r.date_error) begin
      return r;
    end
    span = day_index(d2, m2, y2) - day_index(d1, m1, y1);
    if (end_day) begin
      span += (span >= 0) ? 1 : -1;
    end
    if (span > DIFF_MAX) begin
      span = DIFF_MAX;
    end
    if (span < DIFF_MIN) begin
      span = DIFF_MIN;
    end
    r.day_difference = span[DIFF_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns: day count check: %s", $time, msg);
    mismatches++;
  endtask

  always @(posedge clk) begin : watch
    day_count_t want;
    if (rst_n) begin
      if (in_mon.valid && in_mon.ready) begin
        expected_counts.push_back(predict_count(
          in_mon.first_day, in_mon.first_month, in_mon.first_year,
          in_mon.second_day, in_mon.second_month, in_mon.second_year,
          in_mon.count_end_day));
      end
      if (out_mon.valid && out_mon.ready) begin
        if (expected_counts.size() == 0) begin
          report_mismatch($sformatf("result beat with nothing expected (diff %0d err %0b)",
                                    out_mon.day_difference, out_mon.date_error));
        end else begin
          want = expected_counts.pop_front();
          if (out_mon.day_difference !== want.day_difference) begin
            report_mismatch($sformatf("day_difference %0d, expected %0d",
                                      out_mon.day_difference, want.day_difference));
          end
          if (out_mon.date_error !== want.date_error) begin
            report_mismatch($sformatf("date_error %0b, expected %0b",
                                      out_mon.date_error, want.date_error));
          end
        end
      end
      outstanding = expected_counts.size();
    end
  end

endmodule

`default_nettype wire

>>> test/tb_gregorian_date_difference.sv
// Testbench top for the date difference block: clock, reset, stimulus, result sink and verdict.
`default_nettype none

module tb_gregorian_date_difference;
  import gdd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LONG_HOLD = 300;

  typedef struct packed {
    logic [DAY_W-1:0]  first_day;
    logic [MON_W-1:0]  first_month;
    logic [YEAR_W-1:0] first_year;
    logic [DAY_W-1:0]  second_day;
    logic [MON_W-1:0]  second_month;
    logic [YEAR_W-1:0] second_year;
    logic              count_end_day;
  } date_pair_t;

  logic clk;
  logic rst_n;
  int   mismatches;
  int   outstanding;
  bit   no_idle;
  bit   hold_results;
  bit   hold_active;

  gdd_in_if  in_ch();
  gdd_out_if out_ch();

  gregorian_date_difference dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_ch),
    .out_chan (out_ch)
  );

  date_diff_checker checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("tb_gregorian_date_difference NOT OK");
    $finish;
  end

  function automatic int unsigned idle_cycles();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (no_idle || roll < 45) begin
      return 0;
    end
    if (roll < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  function automatic date_pair_t pair(
    input int d1, input int m1, input int y1,
    input int d2, input int m2, input int y2, input bit end_day);
    date_pair_t p;
    p.first_day     = d1[DAY_W-1:0];
    p.first_month   = m1[MON_W-1:0];
    p.first_year    = y1[YEAR_W-1:0];
    p.second_day    = d2[DAY_W-1:0];
    p.second_month  = m2[MON_W-1:0];
    p.second_year   = y2[YEAR_W-1:0];
    p.count_end_day = end_day;
    return p;
  endfunction

  // Mostly real dates in the usual year range; some near each other, some
  // with oversized years, and a few that are raw noise on every field.
  function automatic date_pair_t random_pair();
    date_pair_t  p;
    int unsigned roll;
    p    = date_pair_t'({$urandom, $urandom});
    roll = $urandom_range(0, 99);
    if (roll < 10) begin
      return p;
    end
    p.first_month  = MON_W'($urandom_range(MON_JAN, MON_DEC));
    p.second_month = MON_W'($urandom_range(MON_JAN, MON_DEC));
    p.first_day    = DAY_W'(($urandom_range(0, 3) == 0) ? $urandom_range(29, 31)
                                                        : $urandom_range(1, 28));
    p.second_day   = DAY_W'(($urandom_range(0, 3) == 0) ? $urandom_range(29, 31)
                                                        : $urandom_range(1, 28));
    if (roll < 60) begin
      p.first_year  = YEAR_W'($urandom_range(0, 9999));
      p.second_year = YEAR_W'($urandom_range(0, 9999));
    end else if (roll < 75) begin
      p.first_year  = YEAR_W'($urandom_range(0, 2**YEAR_W - 1));
      p.second_year = YEAR_W'($urandom_range(0, 2**YEAR_W - 1));
    end else begin
      p.first_year  = YEAR_W'($urandom_range(0, 9999));
      p.second_year = YEAR_W'(p.first_year + $urandom_range(0, 6) - 3);
    end
    return p;
  endfunction

  task automatic offer_pair(input date_pair_t p);
    int unsigned gap;
    in_ch.valid         <= 1'b1;
    in_ch.first_day     <= p.first_day;
    in_ch.first_month   <= p.first_month;
    in_ch.first_year    <= p.first_year;
    in_ch.second_day    <= p.second_day;
    in_ch.second_month  <= p.second_month;
    in_ch.second_year   <= p.second_year;
    in_ch.count_end_day <= p.count_end_day;
    @(posedge clk);
    while (!in_ch.ready) begin
      @(posedge clk);
    end
    gap = idle_cycles();
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic offer_random(input int n);
    repeat (n) offer_pair(random_pair());
  endtask

  initial begin : result_sink
    int unsigned run;
    int unsigned gap;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) begin
      @(posedge clk);
    end
    forever begin
      if (hold_results) begin
        out_ch.ready <= 1'b0;
        hold_active = 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        hold_results = 1'b0;
        hold_active  = 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        run = $urandom_range(1, 12);
        repeat (run) @(posedge clk);
        gap = idle_cycles();
        if (gap != 0) begin
          out_ch.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  end

  initial begin : stimulus
    date_pair_t directed[$];
    no_idle      = 1'b0;
    hold_results = 1'b0;
    hold_active  = 1'b0;
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.first_day    <= '0;
    in_ch.first_month  <= '0;
    in_ch.first_year   <= '0;
    in_ch.second_day   <= '0;
    in_ch.second_month <= '0;
    in_ch.second_year  <= '0;
    in_ch.count_end_day <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Equal dates, with and without the end day.
    directed.push_back(pair(1, MON_JAN, 2000, 1, MON_JAN, 2000, 1'b0));
    directed.push_back(pair(1, MON_JAN, 2000, 1, MON_JAN, 2000, 1'b1));
    // Whole usual range in both directions.
    directed.push_back(pair(1, MON_JAN, 0, 31, MON_DEC, 9999, 1'b0));
    directed.push_back(pair(1, MON_JAN, 0, 31, MON_DEC, 9999, 1'b1));
    directed.push_back(pair(31, MON_DEC, 9999, 1, MON_JAN, 0, 1'b1));
    // Largest year field: the count saturates both ways; then a span within that last year.
    directed.push_back(pair(1, MON_JAN, 0, 31, MON_DEC, 2**YEAR_W - 1, 1'b1));
    directed.push_back(pair(31, MON_DEC, 2**YEAR_W - 1, 1, MON_JAN, 0, 1'b1));
    directed.push_back(pair(31, MON_DEC, 2**YEAR_W - 1, 1, MON_JAN, 2**YEAR_W - 1, 1'b0));
    // Leap day in a 400 year, a plain leap year and year 0; a century and a common year.
    directed.push_back(pair(29, MON_FEB, 2000, 1, MON_MAR, 2000, 1'b0));
    directed.push_back(pair(29, MON_FEB, 2024, 28, MON_FEB, 2024, 1'b1));
    directed.push_back(pair(29, MON_FEB, 0, 1, MON_JAN, 1, 1'b0));
    directed.push_back(pair(29, MON_FEB, 1900, 1, MON_MAR, 1900, 1'b0));
    directed.push_back(pair(1, MON_MAR, 2023, 29, MON_FEB, 2023, 1'b0));
    directed.push_back(pair(28, MON_FEB, 2100, 1, MON_MAR, 2100, 1'b0));
    // One day back, with the end day counted.
    directed.push_back(pair(2, MON_JAN, 2001, 1, MON_JAN, 2001, 1'b1));
    // Bad day or month in either date.
    directed.push_back(pair(0, MON_JAN, 2000, 1, MON_JAN, 2001, 1'b0));
    directed.push_back(pair(1, 0, 2000, 1, MON_JAN, 2001, 1'b1));
    directed.push_back(pair(1, MON_JAN, 2000, 1, MON_DEC + 1, 2001, 1'b0));
    directed.push_back(pair(31, MON_JAN, 2000, 31, 2**MON_W - 1, 2001, 1'b0));
    directed.push_back(pair(31, MON_APR, 2000, 30, MON_APR, 2000, 1'b0));
    directed.push_back(pair(1, MON_JUN, 2000, 31, MON_JUN, 2000, 1'b1));
    directed.push_back(pair(2**DAY_W - 1, MON_JUL, 2**YEAR_W - 1, 0, 0, 0, 1'b1));
    foreach (directed[i]) begin
      offer_pair(directed[i]);
    end

    // Let everything drain before the random traffic starts.
    in_ch.valid <= 1'b0;
    @(posedge clk);
    wait (outstanding == 0);
    @(posedge clk);

    offer_random(35);

    // Stall the result side for a long stretch while input beats keep coming.
    hold_results = 1'b1;
    wait (hold_active);
    no_idle = 1'b1;
    offer_random(10);
    // A stretch with no idling on either side.
    offer_random(15);
    no_idle = 1'b0;

    offer_random(20);
    in_ch.valid <= 1'b0;

    // By this edge the checker has seen the last input beat.
    @(posedge clk);
    wait (outstanding == 0);
    repeat (40) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("tb_gregorian_date_difference OK");
    end else begin
      $display("tb_gregorian_date_difference NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire
